// ===== design/fskg_pkg.sv =====
// ----------------------------------------------------------------------------
// fskg_pkg
// Shared constants, types and arithmetic helpers of the free-space graph
// builder.
// ----------------------------------------------------------------------------
package fskg_pkg;

  localparam int MAX_POINTS = 256;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int LINK_SLOTS = 7;
  localparam int SLOT_W     = $clog2(LINK_SLOTS + 1);
  localparam int COORD_W    = 16;
  localparam int CFG_W      = 15;
  localparam int K_W        = 4;
  localparam int IDX_W      = 3;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int SQ_W       = 2 * COORD_W + 2;
  localparam int HALF_W     = SQ_W / 2;
  localparam int WIDE_W     = 2 * SQ_W;
  localparam int RSQ_W      = 2 * CFG_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } vec_t;

  typedef struct packed {
    logic              vld;
    logic [SQ_W-1:0]   dsq;
    logic [ADDR_W-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] idx;
    logic [SQ_W-1:0]   uu;
    logic [SQ_W-1:0]   dxy;
    diff_t             dz;
  } near_t;

  typedef struct packed {
    logic vld;
    logic hit;
  } hit_t;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FREE_THRESHOLD  = 3'd0,
    REG_CYL_HEIGHT      = 3'd1,
    REG_CYL_RADIUS      = 3'd2,
    REG_LINK_RADIUS     = 3'd3,
    REG_NEIGHBOR_COUNT  = 3'd4,
    REG_MAX_LINK_LENGTH = 3'd5
  } reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_SCAN,
    ST_LD_DRAIN,
    ST_LD_WR,
    ST_Q_RD,
    ST_Q_LAT,
    ST_QS_SCAN,
    ST_QS_DRAIN,
    ST_LK_NEXT,
    ST_LK_LAT,
    ST_LK_DIFF,
    ST_LK_SQ,
    ST_LK_DD,
    ST_LK_CHK,
    ST_LK_SCAN,
    ST_LK_DRAIN,
    ST_LK_END,
    ST_OUT
  } state_t;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    sub_c = diff_t'(a) - diff_t'(b);
  endfunction

  function automatic prod_t mul_d(diff_t a, diff_t b);
    mul_d = prod_t'(a) * prod_t'(b);
  endfunction

endpackage

// ===== design/free_space_knn_graph_builder.sv =====
// ----------------------------------------------------------------------------
// free_space_knn_graph_builder
// Loads points into occupied and free stores and answers link queries for a
// free node with collision-checked nearest neighbors.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; the block then
// holds busy until it is done. An occupied point and a clear never raise busy.
// A free point holds busy while it scans the occupied store through the
// geometry pipeline one point per cycle and drains it. A query holds busy for
// one pass over the free store into the sorted candidate chain, then one pass
// over the occupied store per candidate found (at most 7), skipped when the
// store is empty or the candidate is within unit distance of the node. The
// result is shown for the single cycle done is high and must be taken then;
// there is no stall from the receiver. Loads and clears give no result.
module free_space_knn_graph_builder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  output logic                              done,
  input  logic                              wr_en,
  input  logic [fskg_pkg::IDX_W-1:0]        wr_index,
  input  logic [fskg_pkg::CFG_W-1:0]        wr_data,
  input  logic [1:0]                        req_type,
  input  logic signed [fskg_pkg::COORD_W-1:0] coord_x,
  input  logic signed [fskg_pkg::COORD_W-1:0] coord_y,
  input  logic signed [fskg_pkg::COORD_W-1:0] coord_z,
  input  logic [fskg_pkg::ADDR_W-1:0]       query_node,
  output logic [fskg_pkg::ADDR_W-1:0]       node_id,
  output logic                              node_valid,
  output logic [fskg_pkg::CNT_W-1:0]        free_total,
  output logic [fskg_pkg::SLOT_W-1:0]       link_total,
  output logic [fskg_pkg::ADDR_W-1:0]       link_a,
  output logic [fskg_pkg::ADDR_W-1:0]       link_b,
  output logic [fskg_pkg::ADDR_W-1:0]       link_c,
  output logic [fskg_pkg::ADDR_W-1:0]       link_d,
  output logic [fskg_pkg::ADDR_W-1:0]       link_e,
  output logic [fskg_pkg::ADDR_W-1:0]       link_f,
  output logic [fskg_pkg::ADDR_W-1:0]       link_g
);
  import fskg_pkg::*;

  state_t            state, state_next;
  logic [CFG_W-1:0]  free_threshold, cyl_height, cyl_radius, link_radius;
  logic [CFG_W-1:0]  max_link_length;
  logic [K_W-1:0]    neighbor_count;
  logic [RSQ_W-1:0]  sr2, lr2, md2;
  logic [CNT_W-1:0]  occ_count, free_count, scnt;
  logic [ADDR_W-1:0] node;
  point_t            pa, pb, in_pt, occ_rdata, free_rdata, geom_q;
  vec_t              d;
  prod_t             dsq_p [3];
  dot_t              dd_sum;
  logic [SQ_W-1:0]   dd;
  logic              acc;
  logic [SLOT_W-1:0] c_idx, ltotal, want;
  logic [ADDR_W-1:0] slots [LINK_SLOTS];

  logic              accept, in_occ, occ_we, free_we, iss, cell_clr, cell_ins;
  logic [ADDR_W-1:0] free_raddr;
  near_t             near;
  hit_t              hit;
  logic              geom_busy, cyl_hit;
  cand_t             cands [LINK_SLOTS+1];
  cand_t             cand_new, cand_sel;
  logic              lts [LINK_SLOTS+1];

  assign accept = start && !busy;
  assign in_pt  = '{x: coord_x, y: coord_y, z: coord_z};
  assign in_occ = $signed(coord_z) >= $signed({1'b0, free_threshold});

  always_comb begin
    if (neighbor_count <= K_W'(1)) begin
      want = '0;
    end else if (neighbor_count > K_W'(LINK_SLOTS + 1)) begin
      want = SLOT_W'(LINK_SLOTS);
    end else begin
      want = SLOT_W'(neighbor_count - K_W'(1));
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      free_threshold  <= CFG_W'(102);
      cyl_height      <= CFG_W'(1229);
      cyl_radius      <= CFG_W'(768);
      link_radius     <= CFG_W'(410);
      neighbor_count  <= K_W'(6);
      max_link_length <= CFG_W'(2048);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FREE_THRESHOLD:  free_threshold  <= wr_data;
        REG_CYL_HEIGHT:      cyl_height      <= wr_data;
        REG_CYL_RADIUS:      cyl_radius      <= wr_data;
        REG_LINK_RADIUS:     link_radius     <= wr_data;
        REG_NEIGHBOR_COUNT:  neighbor_count  <= wr_data[K_W-1:0];
        REG_MAX_LINK_LENGTH: max_link_length <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sr2 <= cyl_radius * cyl_radius;
    lr2 <= link_radius * link_radius;
    md2 <= max_link_length * max_link_length;
  end

  // stores
  fskg_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_count[ADDR_W-1:0]),
    .wdata (in_pt),
    .raddr (scnt[ADDR_W-1:0]),
    .rdata (occ_rdata)
  );

  fskg_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_count[ADDR_W-1:0]),
    .wdata (pa),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  assign geom_q = (state == ST_QS_SCAN || state == ST_QS_DRAIN) ? free_rdata : occ_rdata;

  fskg_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .iss     (iss),
    .iss_idx (scnt[ADDR_W-1:0]),
    .q       (geom_q),
    .pa      (pa),
    .pb      (pb),
    .d       (d),
    .dd      (dd),
    .r2      (lr2),
    .near    (near),
    .hit     (hit),
    .busy    (geom_busy)
  );

  assign cyl_hit = near.vld && !near.dz[DIFF_W-1]
                && ({1'b0, near.dz[DIFF_W-2:0]} <= (DIFF_W)'(cyl_height))
                && (near.dxy <= SQ_W'(sr2));

  // candidate chain
  assign cand_new.vld  = 1'b1;
  assign cand_new.dsq  = near.uu;
  assign cand_new.idx  = near.idx;
  assign cands[0]      = '0;
  assign lts[0]        = 1'b0;
  assign cell_ins      = near.vld && (state == ST_QS_SCAN || state == ST_QS_DRAIN)
                      && (near.idx != node) && (near.uu <= SQ_W'(md2));

  for (genvar i = 0; i < LINK_SLOTS; i++) begin : g_cell
    fskg_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (cell_clr),
      .ins     (cell_ins),
      .ena     (SLOT_W'(i) < want),
      .cin     (cand_new),
      .prev_lt (lts[i]),
      .prev    (cands[i]),
      .lt      (lts[i+1]),
      .c       (cands[i+1])
    );
  end

  assign cand_sel = cands[c_idx + SLOT_W'(1)];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_LOAD:  state_next = in_occ ? ST_IDLE : ST_LD_SCAN;
            REQ_QUERY: state_next = ({1'b0, query_node} >= free_count || want == '0) ?
                                    ST_OUT : ST_Q_RD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_LD_SCAN:  if (scnt == occ_count) state_next = ST_LD_DRAIN;
      ST_LD_DRAIN: if (!geom_busy) state_next = ST_LD_WR;
      ST_LD_WR:    state_next = ST_IDLE;
      ST_Q_RD:     state_next = ST_Q_LAT;
      ST_Q_LAT:    state_next = ST_QS_SCAN;
      ST_QS_SCAN:  if (scnt == free_count) state_next = ST_QS_DRAIN;
      ST_QS_DRAIN: if (!geom_busy) state_next = ST_LK_NEXT;
      ST_LK_NEXT:  state_next = (c_idx < SLOT_W'(LINK_SLOTS) && cand_sel.vld) ?
                                ST_LK_LAT : ST_OUT;
      ST_LK_LAT:   state_next = ST_LK_DIFF;
      ST_LK_DIFF:  state_next = ST_LK_SQ;
      ST_LK_SQ:    state_next = ST_LK_DD;
      ST_LK_DD:    state_next = ST_LK_CHK;
      ST_LK_CHK:   state_next = (occ_count == '0 || dd <= SQ_W'(1)) ? ST_LK_END : ST_LK_SCAN;
      ST_LK_SCAN:  if (scnt == occ_count) state_next = ST_LK_DRAIN;
      ST_LK_DRAIN: if (!geom_busy) state_next = ST_LK_END;
      ST_LK_END:   state_next = ST_LK_NEXT;
      ST_OUT:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy       = (state != ST_IDLE);
    done       = (state == ST_OUT);
    occ_we     = (state == ST_IDLE) && accept && (req_type == REQ_LOAD) && in_occ
              && (occ_count < CNT_W'(MAX_POINTS));
    free_we    = (state == ST_LD_WR) && !acc && (free_count < CNT_W'(MAX_POINTS));
    iss        = 1'b0;
    cell_clr   = (state == ST_Q_LAT);
    free_raddr = scnt[ADDR_W-1:0];
    unique case (state)
      ST_Q_RD:    free_raddr = node;
      ST_LK_NEXT: free_raddr = cand_sel.idx;
      ST_LD_SCAN: iss = (scnt != occ_count);
      ST_QS_SCAN: iss = (scnt != free_count);
      ST_LK_SCAN: iss = (scnt != occ_count);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ_count  <= '0;
      free_count <= '0;
    end else begin
      if (accept && req_type == REQ_CLEAR) begin
        occ_count  <= '0;
        free_count <= '0;
      end
      if (occ_we) begin
        occ_count <= occ_count + CNT_W'(1);
      end
      if (free_we) begin
        free_count <= free_count + CNT_W'(1);
      end
    end
  end

  assign dd_sum = dot_t'(dsq_p[0]) + dot_t'(dsq_p[1]) + dot_t'(dsq_p[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= 1'b0;
      c_idx  <= '0;
      ltotal <= '0;
      scnt   <= '0;
    end else begin
      if (iss) begin
        scnt <= scnt + CNT_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            scnt   <= '0;
            acc    <= 1'b0;
            c_idx  <= '0;
            ltotal <= '0;
          end
        end
        ST_LD_SCAN, ST_LD_DRAIN: if (cyl_hit) acc <= 1'b1;
        ST_Q_LAT:  scnt <= '0;
        ST_LK_CHK: begin
          scnt <= '0;
          acc  <= (occ_count != '0) && (dd <= SQ_W'(1));
        end
        ST_LK_SCAN, ST_LK_DRAIN: if (hit.vld && hit.hit) acc <= 1'b1;
        ST_LK_END: begin
          c_idx <= c_idx + SLOT_W'(1);
          if (!acc) begin
            ltotal <= ltotal + SLOT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          pa   <= in_pt;
          node <= query_node;
          for (int i = 0; i < LINK_SLOTS; i++) begin
            slots[i] <= '0;
          end
        end
      end
      ST_Q_LAT: begin
        pa <= free_rdata;
        pb <= free_rdata;
      end
      ST_LK_LAT:  pa <= free_rdata;
      ST_LK_DIFF: begin
        d.x <= sub_c(pb.x, pa.x);
        d.y <= sub_c(pb.y, pa.y);
        d.z <= sub_c(pb.z, pa.z);
      end
      ST_LK_SQ: begin
        dsq_p[0] <= mul_d(d.x, d.x);
        dsq_p[1] <= mul_d(d.y, d.y);
        dsq_p[2] <= mul_d(d.z, d.z);
      end
      ST_LK_DD: dd <= dd_sum[SQ_W-1:0];
      ST_LK_END: if (!acc) slots[ltotal] <= cand_sel.idx;
      default: ;
    endcase
  end

  assign node_id    = node;
  assign node_valid = ({1'b0, node} < free_count);
  assign free_total = free_count;
  assign link_total = ltotal;
  assign link_a     = slots[0];
  assign link_b     = slots[1];
  assign link_c     = slots[2];
  assign link_d     = slots[3];
  assign link_e     = slots[4];
  assign link_f     = slots[5];
  assign link_g     = slots[6];

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !geom_busy)
    else $error("geometry pipeline busy while idle");

  a_free_room: assert property (@(posedge clk) disable iff (rst)
    free_we |-> (free_count < CNT_W'(MAX_POINTS)))
    else $error("free store written when full");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_links_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> (link_total <= want))
    else $error("more links than requested neighbors");

  a_chain_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LK_NEXT && cands[2].vld) |-> (cands[1].vld && cands[1].dsq <= cands[2].dsq))
    else $error("candidate chain out of order");

endmodule

// ===== design/fskg_ram.sv =====
// ----------------------------------------------------------------------------
// fskg_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module fskg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fskg_cell.sv =====
// ----------------------------------------------------------------------------
// fskg_cell
// One slot of the sorted candidate chain: takes a new entry or its left
// neighbor's entry when a closer candidate arrives.
// ----------------------------------------------------------------------------
module fskg_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           clr,
  input  logic           ins,
  input  logic           ena,
  input  fskg_pkg::cand_t cin,
  input  logic           prev_lt,
  input  fskg_pkg::cand_t prev,
  output logic           lt,
  output fskg_pkg::cand_t c
);
  import fskg_pkg::*;

  assign lt = ena && (!c.vld || (cin.dsq < c.dsq));

  always_ff @(posedge clk) begin
    if (ins && lt) begin
      c.dsq <= prev_lt ? prev.dsq : cin.dsq;
      c.idx <= prev_lt ? prev.idx : cin.idx;
    end
    if (rst || clr) begin
      c.vld <= 1'b0;
    end else if (ins && lt) begin
      c.vld <= prev_lt ? prev.vld : cin.vld;
    end
  end

endmodule

// ===== design/fskg_geom.sv =====
// ----------------------------------------------------------------------------
// fskg_geom
// Pipelined point geometry: offsets, squared distances, and the segment
// clearance test against one stored point per cycle.
// ----------------------------------------------------------------------------
module fskg_geom (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          iss,
  input  logic [fskg_pkg::ADDR_W-1:0]   iss_idx,
  input  fskg_pkg::point_t              q,
  input  fskg_pkg::point_t              pa,
  input  fskg_pkg::point_t              pb,
  input  fskg_pkg::vec_t                d,
  input  logic [fskg_pkg::SQ_W-1:0]     dd,
  input  logic [fskg_pkg::RSQ_W-1:0]    r2,
  output fskg_pkg::near_t               near,
  output fskg_pkg::hit_t                hit,
  output logic                          busy
);
  import fskg_pkg::*;

  logic              s0_vld, s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld;
  logic [ADDR_W-1:0] s0_idx, s1_idx, s2_idx, s3_idx;
  diff_t             s1_u [3];
  diff_t             s1_w [3];
  prod_t             s2_uu [3];
  prod_t             s2_ud [3];
  prod_t             s2_wd [3];
  diff_t             s2_dz, s3_dz;
  dot_t              s3_uu, s3_lid, s3_wd;
  logic [SQ_W-1:0]   s3_dxy;
  logic              s4_skip, s4_neg, s5_skip, s5_neg, s6_skip, s6_neg, s7_hit;
  logic [SQ_W-1:0]   s4_lhs, s4_lid;
  logic [2*HALF_W-1:0] s5_ahh, s5_ahl, s5_alh, s5_all;
  logic [2*HALF_W-1:0] s5_bhh, s5_bhl, s5_blh, s5_bll;
  logic [WIDE_W-1:0] s6_lp, s6_rp;
  dot_t              lhs_c;
  prod_t             dxy_c;

  assign lhs_c = s3_uu - dot_t'({1'b0, r2});
  assign dxy_c = s2_uu[0] + s2_uu[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else begin
      s0_vld <= iss;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx <= iss_idx;
    s1_idx <= s0_idx;
    s2_idx <= s1_idx;
    s3_idx <= s2_idx;

    s1_u[0] <= sub_c(q.x, pa.x);
    s1_u[1] <= sub_c(q.y, pa.y);
    s1_u[2] <= sub_c(q.z, pa.z);
    s1_w[0] <= sub_c(q.x, pb.x);
    s1_w[1] <= sub_c(q.y, pb.y);
    s1_w[2] <= sub_c(q.z, pb.z);

    s2_uu[0] <= mul_d(s1_u[0], s1_u[0]);
    s2_uu[1] <= mul_d(s1_u[1], s1_u[1]);
    s2_uu[2] <= mul_d(s1_u[2], s1_u[2]);
    s2_ud[0] <= mul_d(s1_u[0], d.x);
    s2_ud[1] <= mul_d(s1_u[1], d.y);
    s2_ud[2] <= mul_d(s1_u[2], d.z);
    s2_wd[0] <= mul_d(s1_w[0], d.x);
    s2_wd[1] <= mul_d(s1_w[1], d.y);
    s2_wd[2] <= mul_d(s1_w[2], d.z);
    s2_dz    <= s1_u[2];

    s3_uu  <= dot_t'(s2_uu[0]) + dot_t'(s2_uu[1]) + dot_t'(s2_uu[2]);
    s3_lid <= dot_t'(s2_ud[0]) + dot_t'(s2_ud[1]) + dot_t'(s2_ud[2]);
    s3_wd  <= dot_t'(s2_wd[0]) + dot_t'(s2_wd[1]) + dot_t'(s2_wd[2]);
    s3_dxy <= dxy_c[SQ_W-1:0];
    s3_dz  <= s2_dz;

    s4_skip <= s3_lid[DOT_W-1] || (!s3_wd[DOT_W-1] && (s3_wd != '0));
    s4_neg  <= lhs_c[DOT_W-1];
    s4_lhs  <= lhs_c[SQ_W-1:0];
    s4_lid  <= s3_lid[SQ_W-1:0];

    s5_skip <= s4_skip;
    s5_neg  <= s4_neg;
    s5_ahh  <= s4_lhs[SQ_W-1:HALF_W] * dd[SQ_W-1:HALF_W];
    s5_ahl  <= s4_lhs[SQ_W-1:HALF_W] * dd[HALF_W-1:0];
    s5_alh  <= s4_lhs[HALF_W-1:0] * dd[SQ_W-1:HALF_W];
    s5_all  <= s4_lhs[HALF_W-1:0] * dd[HALF_W-1:0];
    s5_bhh  <= s4_lid[SQ_W-1:HALF_W] * s4_lid[SQ_W-1:HALF_W];
    s5_bhl  <= s4_lid[SQ_W-1:HALF_W] * s4_lid[HALF_W-1:0];
    s5_blh  <= s4_lid[HALF_W-1:0] * s4_lid[SQ_W-1:HALF_W];
    s5_bll  <= s4_lid[HALF_W-1:0] * s4_lid[HALF_W-1:0];

    s6_skip <= s5_skip;
    s6_neg  <= s5_neg;
    s6_lp   <= (WIDE_W'(s5_ahh) << (2 * HALF_W)) + (WIDE_W'(s5_ahl) << HALF_W)
             + (WIDE_W'(s5_alh) << HALF_W) + WIDE_W'(s5_all);
    s6_rp   <= (WIDE_W'(s5_bhh) << (2 * HALF_W)) + (WIDE_W'(s5_bhl) << HALF_W)
             + (WIDE_W'(s5_blh) << HALF_W) + WIDE_W'(s5_bll);

    s7_hit  <= !s6_skip && (s6_neg || (s6_lp < s6_rp));
  end

  assign near.vld = s3_vld;
  assign near.idx = s3_idx;
  assign near.uu  = s3_uu[SQ_W-1:0];
  assign near.dxy = s3_dxy;
  assign near.dz  = s3_dz;
  assign hit.vld  = s7_vld;
  assign hit.hit  = s7_hit;
  assign busy     = s0_vld | s1_vld | s2_vld | s3_vld | s4_vld | s5_vld | s6_vld | s7_vld;

endmodule
